[rtl/qgai_pkg.sv]
// ----------------------------------------------------------------------------
// qgai_pkg
// Shared types and constants of the gyro attitude integrator: fixed-point
// constants, datapath command encodings and the controller/datapath structs.
// ----------------------------------------------------------------------------
package qgai_pkg;

  // Field and register widths.
  localparam int unsigned GyroW = 32;
  localparam int unsigned QuatW = 32;
  localparam int unsigned HtsW  = 32;
  localparam int unsigned OpndW = 33;
  localparam int unsigned ProdW = 66;
  localparam int unsigned GW    = 31;
  localparam int unsigned RemW  = 35;

  // Reset values of the configuration registers.
  localparam logic [HtsW-1:0] HtsReset = 32'd2147484;
  localparam logic            NenReset = 1'b1;

  // One in Q2.30.
  localparam logic signed [QuatW-1:0] OneQ30 = 32'sd1073741824;

  // Configuration register indexes.
  typedef enum logic {
    REG_HTS = 1'b0,
    REG_NEN = 1'b1
  } reg_idx_e;

  // Multiplier operand A selects.
  typedef enum logic [2:0] {
    A_Q0, A_Q1, A_Q2, A_Q3, A_GX, A_GY, A_GZ
  } asel_e;

  // Multiplier operand B selects.
  typedef enum logic [3:0] {
    B_Q0, B_Q1, B_Q2, B_Q3, B_G0, B_G1, B_G2, B_HTS, B_ONE
  } bsel_e;

  // What the accumulator stage does with the product in the following cycle.
  typedef enum logic [2:0] {
    P_NOP, P_LOAD, P_ADD, P_SUB, P_ST_G, P_ST_NQ, P_ST_ROT, P_ST_SQ
  } post_e;

  // Rounding bias loaded with the first product of a sum.
  typedef enum logic [2:0] {
    BI_ZERO, BI_RATE, BI_INT, BI_ROT, BI_DIAG
  } bias_e;

  // One multiply/accumulate command.
  typedef struct packed {
    asel_e       asel;
    bsel_e       bsel;
    post_e       post;
    bias_e       bias;
    logic [2:0]  idx;
  } mcmd_t;

  // Controller to datapath commands.
  typedef struct packed {
    mcmd_t       mc;
    logic        capture;
    logic        clear;
    logic        commit;
    logic        sqrt_step;
    logic        r_load;
    logic        div_init;
    logic        div_step;
    logic        div_store;
    logic [1:0]  comp;
    logic        out_load;
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic r_zero;
    logic out_free;
    logic nen;
  } sts_t;

endpackage

[rtl/qgai_ctrl.sv]
// ----------------------------------------------------------------------------
// qgai_ctrl
// Controller of the gyro attitude integrator. Sequences the shared multiplier
// through rate scaling, integration, squared norm and rotation entries, and
// steps the shared square-root/divide unit during normalization.
// ----------------------------------------------------------------------------
module qgai_ctrl
  import qgai_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_op_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_CLR    = 16'h0002,
    ST_RATE   = 16'h0004,
    ST_INT    = 16'h0008,
    ST_IDRN   = 16'h0010,
    ST_COMMIT = 16'h0020,
    ST_SQ     = 16'h0040,
    ST_SDRN   = 16'h0080,
    ST_SQRT   = 16'h0100,
    ST_RCHK   = 16'h0200,
    ST_DINIT  = 16'h0400,
    ST_DIV    = 16'h0800,
    ST_DST    = 16'h1000,
    ST_ROT    = 16'h2000,
    ST_RDRN   = 16'h4000,
    ST_OUT    = 16'h8000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] comp_q, comp_d;
  logic [2:0] term_q, term_d;
  logic [4:0] iter_q, iter_d;
  logic       accept;

  // Quaternion component as operand A or B.
  function automatic asel_e qa(input logic [1:0] i);
    asel_e r;
    case (i)
      2'd0:    r = A_Q0;
      2'd1:    r = A_Q1;
      2'd2:    r = A_Q2;
      default: r = A_Q3;
    endcase
    return r;
  endfunction

  function automatic bsel_e qb(input logic [1:0] i);
    bsel_e r;
    case (i)
      2'd0:    r = B_Q0;
      2'd1:    r = B_Q1;
      2'd2:    r = B_Q2;
      default: r = B_Q3;
    endcase
    return r;
  endfunction

  function automatic mcmd_t nop_cmd();
    mcmd_t c;
    c.asel = A_Q0;
    c.bsel = B_ONE;
    c.post = P_NOP;
    c.bias = BI_ZERO;
    c.idx  = 3'd0;
    return c;
  endfunction

  // Rate scaling: gyro times half step, then store the clamped rate.
  function automatic mcmd_t mc_rate(input logic [2:0] c, input logic [2:0] t);
    mcmd_t m;
    m = nop_cmd();
    m.idx = c;
    if (t == 3'd0) begin
      case (c[1:0])
        2'd0:    m.asel = A_GX;
        2'd1:    m.asel = A_GY;
        default: m.asel = A_GZ;
      endcase
      m.bsel = B_HTS;
      m.post = P_LOAD;
      m.bias = BI_RATE;
    end else begin
      m.post = P_ST_G;
    end
    return m;
  endfunction

  // Integration: q[c] * one plus three signed rate terms, then store.
  function automatic mcmd_t mc_int(input logic [2:0] c, input logic [2:0] t);
    mcmd_t m;
    logic  neg;
    m = nop_cmd();
    m.idx = c;
    case (c[1:0])
      2'd0:    neg = 1'b1;
      2'd1:    neg = (t == 3'd2);
      2'd2:    neg = (t == 3'd3);
      default: neg = (t == 3'd1);
    endcase
    case (t)
      3'd0: begin
        m.asel = qa(c[1:0]);
        m.bsel = B_ONE;
        m.post = P_LOAD;
        m.bias = BI_INT;
      end
      3'd1, 3'd2, 3'd3: begin
        m.asel = qa(c[1:0] ^ t[1:0]);
        case (t[1:0])
          2'd1:    m.bsel = B_G0;
          2'd2:    m.bsel = B_G1;
          default: m.bsel = B_G2;
        endcase
        m.post = neg ? P_SUB : P_ADD;
      end
      default: m.post = P_ST_NQ;
    endcase
    return m;
  endfunction

  // Squared norm: sum of the four squares, then hand it to the root unit.
  function automatic mcmd_t mc_sq(input logic [2:0] c);
    mcmd_t m;
    m = nop_cmd();
    if (c == 3'd4) begin
      m.post = P_ST_SQ;
    end else begin
      m.asel = qa(c[1:0]);
      m.bsel = qb(c[1:0]);
      m.post = (c == 3'd0) ? P_LOAD : P_ADD;
    end
    return m;
  endfunction

  // Rotation entries: two products each, then store the rounded entry.
  function automatic mcmd_t mc_rot(input logic [2:0] e, input logic [2:0] t);
    mcmd_t      m;
    logic [1:0] a0, b0, a1, b1;
    m = nop_cmd();
    m.idx = e;
    case (e)
      3'd0:    begin a0 = 2'd0; b0 = 2'd0; a1 = 2'd1; b1 = 2'd1; end
      3'd1:    begin a0 = 2'd1; b0 = 2'd2; a1 = 2'd0; b1 = 2'd3; end
      3'd2:    begin a0 = 2'd1; b0 = 2'd3; a1 = 2'd0; b1 = 2'd2; end
      3'd3:    begin a0 = 2'd2; b0 = 2'd3; a1 = 2'd0; b1 = 2'd1; end
      default: begin a0 = 2'd0; b0 = 2'd0; a1 = 2'd3; b1 = 2'd3; end
    endcase
    case (t)
      3'd0: begin
        m.asel = qa(a0);
        m.bsel = qb(b0);
        m.post = P_LOAD;
        m.bias = (e == 3'd0 || e == 3'd4) ? BI_DIAG : BI_ROT;
      end
      3'd1: begin
        m.asel = qa(a1);
        m.bsel = qb(b1);
        m.post = (e == 3'd2) ? P_SUB : P_ADD;
      end
      default: m.post = P_ST_ROT;
    endcase
    return m;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  // Next state, counters and commands.
  always_comb begin
    state_d = state_q;
    comp_d  = comp_q;
    term_d  = term_q;
    iter_d  = iter_q;
    ctl_o   = '0;
    ctl_o.mc      = nop_cmd();
    ctl_o.capture = accept;
    ctl_o.comp    = comp_q[1:0];
    unique case (state_q)
      ST_IDLE: begin
        comp_d = '0;
        term_d = '0;
        if (accept) begin
          state_d = in_op_i ? ST_CLR : ST_RATE;
        end
      end
      ST_CLR: begin
        ctl_o.clear = 1'b1;
        state_d     = ST_ROT;
      end
      ST_RATE: begin
        ctl_o.mc = mc_rate(comp_q, term_q);
        if (term_q == 3'd1) begin
          term_d = '0;
          if (comp_q == 3'd2) begin
            comp_d  = '0;
            state_d = ST_INT;
          end else begin
            comp_d = comp_q + 3'd1;
          end
        end else begin
          term_d = term_q + 3'd1;
        end
      end
      ST_INT: begin
        ctl_o.mc = mc_int(comp_q, term_q);
        if (term_q == 3'd4) begin
          term_d = '0;
          if (comp_q == 3'd3) begin
            comp_d  = '0;
            state_d = ST_IDRN;
          end else begin
            comp_d = comp_q + 3'd1;
          end
        end else begin
          term_d = term_q + 3'd1;
        end
      end
      ST_IDRN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        ctl_o.commit = 1'b1;
        state_d      = sts_i.nen ? ST_SQ : ST_ROT;
      end
      ST_SQ: begin
        ctl_o.mc = mc_sq(comp_q);
        if (comp_q == 3'd4) begin
          comp_d  = '0;
          state_d = ST_SDRN;
        end else begin
          comp_d = comp_q + 3'd1;
        end
      end
      ST_SDRN: begin
        iter_d  = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        ctl_o.sqrt_step = 1'b1;
        iter_d          = iter_q + 5'd1;
        if (iter_q == 5'd31) begin
          state_d = ST_RCHK;
        end
      end
      ST_RCHK: begin
        ctl_o.r_load = 1'b1;
        comp_d       = '0;
        state_d      = sts_i.r_zero ? ST_ROT : ST_DINIT;
      end
      ST_DINIT: begin
        ctl_o.div_init = 1'b1;
        iter_d         = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        ctl_o.div_step = 1'b1;
        iter_d         = iter_q + 5'd1;
        if (iter_q == 5'd31) begin
          state_d = ST_DST;
        end
      end
      ST_DST: begin
        ctl_o.div_store = 1'b1;
        if (comp_q == 3'd3) begin
          comp_d  = '0;
          state_d = ST_ROT;
        end else begin
          comp_d  = comp_q + 3'd1;
          state_d = ST_DINIT;
        end
      end
      ST_ROT: begin
        ctl_o.mc = mc_rot(comp_q, term_q);
        if (term_q == 3'd2) begin
          term_d = '0;
          if (comp_q == 3'd4) begin
            comp_d  = '0;
            state_d = ST_RDRN;
          end else begin
            comp_d = comp_q + 3'd1;
          end
        end else begin
          term_d = term_q + 3'd1;
        end
      end
      ST_RDRN: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      comp_q  <= '0;
      term_q  <= '0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      comp_q  <= comp_d;
      term_q  <= term_d;
      iter_q  <= iter_d;
    end
  end

endmodule

[rtl/qgai_dp.sv]
// ----------------------------------------------------------------------------
// qgai_dp
// Datapath of the gyro attitude integrator: configuration registers, attitude
// state, one shared 33x33 multiplier with a rounding accumulator, a shared
// one-bit-per-cycle square-root/divide unit and the output word register.
// ----------------------------------------------------------------------------
module qgai_dp
  import qgai_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  reg_idx_e                  cfg_idx_i,
  input  logic [HtsW-1:0]           cfg_wdata_i,
  input  logic [3*GyroW-1:0]        in_data_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [9*QuatW-1:0]        out_data_o,
  input  ctl_t                      ctl_i,
  output sts_t                      sts_o
);

  localparam logic signed [ProdW-1:0] S32Max  = 66'sd2147483647;
  localparam logic signed [ProdW-1:0] S32Min  = -66'sd2147483648;
  localparam logic signed [ProdW-1:0] GLim    = 66'sd1073741823;
  localparam logic signed [ProdW-1:0] BiasRate = 66'sd33554432;
  localparam logic signed [ProdW-1:0] BiasInt  = 66'sd536870912;
  localparam logic signed [ProdW-1:0] BiasRot  = 66'sd268435456;
  localparam logic signed [ProdW-1:0] BiasDiag = BiasRot - (66'sd1 <<< 59);

  logic [HtsW-1:0]              hts_q;
  logic                         nen_q;
  logic signed [GyroW-1:0]      gyro_q [3];
  logic signed [QuatW-1:0]      q_q    [4];
  logic signed [QuatW-1:0]      nq_q   [4];
  logic signed [GW-1:0]         g_q    [3];
  logic signed [QuatW-1:0]      rot_q  [5];
  logic signed [ProdW-1:0]      prod_q, prod_d, acc_q, acc_d, bias_v;
  logic [2:0]                   tidx_q;
  post_e                        tpost_q;
  bias_e                        tbias_q;
  logic signed [OpndW-1:0]      a_op, b_op;
  logic [63:0]                  sh_q;
  logic [RemW-1:0]              rem_q;
  logic [QuatW-1:0]             res_q, r_q;
  logic                         ovf_q, neg_q;
  logic [9*QuatW-1:0]           out_q;
  logic                         out_valid_q;

  // Root and divide step values.
  logic [RemW-1:0]              sq_rem2, sq_trial;
  logic [RemW-2:0]              dv_rem2, dv_den;
  logic [QuatW-1:0]             mag;
  logic [62:0]                  num;
  logic                         sat;
  logic [QuatW-1:0]             qsel;

  function automatic logic signed [QuatW-1:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [QuatW-1:0] r;
    if (v > S32Max) begin
      r = S32Max[QuatW-1:0];
    end else if (v < S32Min) begin
      r = S32Min[QuatW-1:0];
    end else begin
      r = v[QuatW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [GW-1:0] satg(input logic signed [ProdW-1:0] v);
    logic signed [GW-1:0] r;
    if (v > GLim) begin
      r = GLim[GW-1:0];
    end else if (v < -GLim) begin
      r = -GLim[GW-1:0];
    end else begin
      r = v[GW-1:0];
    end
    return r;
  endfunction

  // Multiplier operand selection.
  always_comb begin
    case (ctl_i.mc.asel)
      A_Q0:    a_op = {q_q[0][QuatW-1], q_q[0]};
      A_Q1:    a_op = {q_q[1][QuatW-1], q_q[1]};
      A_Q2:    a_op = {q_q[2][QuatW-1], q_q[2]};
      A_Q3:    a_op = {q_q[3][QuatW-1], q_q[3]};
      A_GX:    a_op = {gyro_q[0][GyroW-1], gyro_q[0]};
      A_GY:    a_op = {gyro_q[1][GyroW-1], gyro_q[1]};
      default: a_op = {gyro_q[2][GyroW-1], gyro_q[2]};
    endcase
    case (ctl_i.mc.bsel)
      B_Q0:    b_op = {q_q[0][QuatW-1], q_q[0]};
      B_Q1:    b_op = {q_q[1][QuatW-1], q_q[1]};
      B_Q2:    b_op = {q_q[2][QuatW-1], q_q[2]};
      B_Q3:    b_op = {q_q[3][QuatW-1], q_q[3]};
      B_G0:    b_op = {{2{g_q[0][GW-1]}}, g_q[0]};
      B_G1:    b_op = {{2{g_q[1][GW-1]}}, g_q[1]};
      B_G2:    b_op = {{2{g_q[2][GW-1]}}, g_q[2]};
      B_HTS:   b_op = {1'b0, hts_q};
      default: b_op = {1'b0, OneQ30};
    endcase
  end

  assign prod_d = a_op * b_op;

  // Accumulator stage: the first product of a sum picks up its rounding bias.
  always_comb begin
    case (tbias_q)
      BI_RATE: bias_v = BiasRate;
      BI_INT:  bias_v = BiasInt;
      BI_ROT:  bias_v = BiasRot;
      BI_DIAG: bias_v = BiasDiag;
      default: bias_v = '0;
    endcase
    case (tpost_q)
      P_LOAD:  acc_d = bias_v + prod_q;
      P_ADD:   acc_d = acc_q + prod_q;
      P_SUB:   acc_d = acc_q - prod_q;
      default: acc_d = acc_q;
    endcase
  end

  // Square-root step: bring down two radicand bits, try 4*root+1.
  assign sq_rem2  = {rem_q[RemW-3:0], sh_q[63:62]};
  assign sq_trial = {1'b0, res_q, 2'b01};

  // Divide step: bring down one numerator bit, try 2*r.
  assign dv_rem2 = {rem_q[RemW-3:0], sh_q[63]};
  assign dv_den  = {1'b0, r_q, 1'b0};

  // Divider setup for the selected component: |q| * 2^31 + r over 2r.
  assign qsel = q_q[ctl_i.comp];
  assign mag  = qsel[QuatW-1] ? (~qsel + 32'd1) : qsel;
  assign num  = {mag, 31'd0} + {31'd0, r_q};
  assign sat  = ovf_q | res_q[QuatW-1];

  // Multiplier, accumulator, input capture, result stores, the shared root/divide registers and the output word.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctl_i.capture) begin
      gyro_q[0] <= in_data_i[GyroW-1:0];
      gyro_q[1] <= in_data_i[2*GyroW-1:GyroW];
      gyro_q[2] <= in_data_i[3*GyroW-1:2*GyroW];
    end
    case (tpost_q)
      P_LOAD, P_ADD, P_SUB: acc_q <= acc_d;
      P_ST_G:   g_q[tidx_q[1:0]]  <= satg(acc_q >>> 26);
      P_ST_NQ:  nq_q[tidx_q[1:0]] <= sat32(acc_q >>> 30);
      P_ST_ROT: rot_q[tidx_q]     <= sat32(acc_q >>> 29);
      default: ;
    endcase
    if (tpost_q == P_ST_SQ) begin
      sh_q  <= (acc_q[ProdW-1:64] != 2'b00) ? '1 : acc_q[63:0];
      rem_q <= '0;
      res_q <= '0;
    end else if (ctl_i.sqrt_step) begin
      sh_q <= {sh_q[61:0], 2'b00};
      if (sq_rem2 >= sq_trial) begin
        rem_q <= sq_rem2 - sq_trial;
        res_q <= {res_q[QuatW-2:0], 1'b1};
      end else begin
        rem_q <= sq_rem2;
        res_q <= {res_q[QuatW-2:0], 1'b0};
      end
    end else if (ctl_i.div_init) begin
      sh_q  <= {num[31:0], 32'd0};
      rem_q <= {4'd0, num[62:32]};
      res_q <= '0;
      ovf_q <= ({3'b000, num[62:32]} >= dv_den);
      neg_q <= qsel[QuatW-1];
    end else if (ctl_i.div_step) begin
      sh_q <= {sh_q[62:0], 1'b0};
      if (dv_rem2 >= dv_den) begin
        rem_q <= {1'b0, dv_rem2 - dv_den};
        res_q <= {res_q[QuatW-2:0], 1'b1};
      end else begin
        rem_q <= {1'b0, dv_rem2};
        res_q <= {res_q[QuatW-2:0], 1'b0};
      end
    end
    if (ctl_i.r_load) begin
      r_q <= res_q;
    end
    if (ctl_i.out_load) begin
      out_q <= {rot_q[4], rot_q[3], rot_q[2], rot_q[1], rot_q[0],
                q_q[3], q_q[2], q_q[1], q_q[0]};
    end
  end

  // Configuration, attitude state, command tag and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hts_q       <= HtsReset;
      nen_q       <= NenReset;
      q_q[0]      <= OneQ30;
      q_q[1]      <= '0;
      q_q[2]      <= '0;
      q_q[3]      <= '0;
      tpost_q     <= P_NOP;
      tbias_q     <= BI_ZERO;
      tidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_HTS: hts_q <= cfg_wdata_i;
          REG_NEN: nen_q <= cfg_wdata_i[0];
        endcase
      end
      tpost_q <= ctl_i.mc.post;
      tbias_q <= ctl_i.mc.bias;
      tidx_q  <= ctl_i.mc.idx;
      if (ctl_i.clear) begin
        q_q[0] <= OneQ30;
        q_q[1] <= '0;
        q_q[2] <= '0;
        q_q[3] <= '0;
      end else if (ctl_i.commit) begin
        q_q <= nq_q;
      end else if (ctl_i.div_store) begin
        if (neg_q) begin
          q_q[ctl_i.comp] <= sat ? S32Min[QuatW-1:0] : (~res_q + 32'd1);
        end else begin
          q_q[ctl_i.comp] <= sat ? S32Max[QuatW-1:0] : res_q;
        end
      end
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.r_zero    = (res_q == '0);
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;
  assign sts_o.nen       = nen_q;

endmodule

[rtl/quaternion_gyro_attitude_integrator.sv]
// ----------------------------------------------------------------------------
// quaternion_gyro_attitude_integrator
// Gyro attitude integrator: first-order quaternion update per gyro word with
// optional exact renormalization and rotation-matrix outputs.
// ----------------------------------------------------------------------------
// The block holds an attitude quaternion in Q2.30 and advances it by one
// first-order step for each gyro word (rates in Q7.24 rad/s scaled by the
// configured half time step), renormalizes it when enabled, and returns the
// quaternion with five rotation-matrix entries; tuser set clears to identity.
// All arithmetic runs through one shared 33x33 multiplier and a shared unit
// that makes one root or quotient bit per cycle. An integration with
// normalization runs the square root and then one division for each of the
// four components, which the controller skips when the root is zero.
// A new word is accepted once the previous one has reached the output
// register, which holds it until the consumer takes it.
module quaternion_gyro_attitude_integrator
  import qgai_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [HtsW-1:0]      cfg_wdata_i,
  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [3*GyroW-1:0]   s_axis_tdata,   // gyro_x, gyro_y, gyro_z
  input  logic                 s_axis_tuser,   // op
  // Output stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [9*QuatW-1:0]   m_axis_tdata    // quat_w, quat_x, quat_y, quat_z,
                                               // rot_00, rot_01, rot_02, rot_12,
                                               // rot_22
);

  ctl_t ctl;
  sts_t sts;

  qgai_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  qgai_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (reg_idx_e'(cfg_idx_i)),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

endmodule

[sim/tb_quaternion_gyro_attitude_integrator.sv]
// ----------------------------------------------------------------------------
// tb_quaternion_gyro_attitude_integrator
// Self-checking testbench of the gyro attitude integrator. It drives gyro and
// clear words with random gaps, predicts each output word from its own model
// of the quaternion update, and compares the results field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quaternion_gyro_attitude_integrator;
  import qgai_pkg::*;

  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;
  localparam longint GLim   = (64'sd1 <<< 30) - 1;
  localparam longint One30  = 64'sd1 <<< 30;
  localparam bit     OpInt  = 1'b0;
  localparam bit     OpClr  = 1'b1;
  localparam longint CycleLimit = 3000000;

  // One output word with its nine fields.
  typedef struct {
    logic signed [31:0] f [9];
  } attitude_word_t;

  // Attitude predictor and queue of expected output words.
  class attitude_scoreboard;
    logic [31:0]        hts;
    bit                 nen;
    longint             q [4];
    attitude_word_t     pending [$];
    int                 errors;

    function new();
      hts = HtsReset; nen = NenReset;
      q[0] = One30; q[1] = 0; q[2] = 0; q[3] = 0;
      errors = 0;
    endfunction

    // Round to nearest, ties toward +infinity.
    function longint rshift(longint v, int s);
      return ((v >>> (s - 1)) + 1) >>> 1;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b); r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void renormalize();
      longint unsigned mag [4], s, sq, r, quo;
      s = 0;
      for (int i = 0; i < 4; i++) begin
        mag[i] = q[i] < 0 ? longint'(-q[i]) : q[i];
        sq = mag[i] * mag[i];
        s = (s > ~64'd0 - sq) ? ~64'd0 : s + sq;
      end
      r = isqrt(s);
      if (r == 0) return;
      for (int i = 0; i < 4; i++) begin
        quo = ((mag[i] << 31) + r) / (2 * r);
        if (q[i] < 0) q[i] = quo >= (64'd1 << 31) ? S32Min : -longint'(quo);
        else q[i] = quo > S32Max ? S32Max : longint'(quo);
      end
    endfunction

    function longint rot_entry(longint a, longint b, bit diag);
      longint s;
      s = (a > 0 && b > 0 && a > 64'sh7fffffffffffffff - b) ? 64'sh7fffffffffffffff
                                                             : a + b;
      if (diag) s = s - (64'sd1 <<< 59);
      return clamp(rshift(s, 29), S32Min, S32Max);
    endfunction

    // Advance the attitude by one accepted input word and queue the result.
    function void note_input(bit op, logic signed [31:0] gx, logic signed [31:0] gy,
                             logic signed [31:0] gz);
      longint g [3], a [4], w, x, y, z;
      logic signed [31:0] gi [3];
      attitude_word_t e;
      gi[0] = gx; gi[1] = gy; gi[2] = gz;
      if (op) begin
        q[0] = One30; q[1] = 0; q[2] = 0; q[3] = 0;
      end else begin
        for (int i = 0; i < 3; i++)
          g[i] = clamp(rshift(longint'(gi[i]) * longint'({32'd0, hts}), 26), -GLim, GLim);
        w = q[0]; x = q[1]; y = q[2]; z = q[3];
        a[0] = w * One30 - x * g[0] - y * g[1] - z * g[2];
        a[1] = x * One30 + w * g[0] - z * g[1] + y * g[2];
        a[2] = y * One30 + z * g[0] + w * g[1] - x * g[2];
        a[3] = z * One30 - y * g[0] + x * g[1] + w * g[2];
        for (int i = 0; i < 4; i++) q[i] = clamp(rshift(a[i], 30), S32Min, S32Max);
        if (nen) renormalize();
      end
      w = q[0]; x = q[1]; y = q[2]; z = q[3];
      for (int i = 0; i < 4; i++) e.f[i] = 32'(q[i]);
      e.f[4] = 32'(rot_entry(w * w, x * x, 1'b1));
      e.f[5] = 32'(rot_entry(x * y, w * z, 1'b0));
      e.f[6] = 32'(rot_entry(x * z, -(w * y), 1'b0));
      e.f[7] = 32'(rot_entry(y * z, w * x, 1'b0));
      e.f[8] = 32'(rot_entry(w * w, z * z, 1'b1));
      pending.push_back(e);
    endfunction

    // Compare one output word with the oldest expectation.
    function void check_output(logic [9*32-1:0] data);
      string names [9] = '{"quat_w", "quat_x", "quat_y", "quat_z", "rot_00",
                           "rot_01", "rot_02", "rot_12", "rot_22"};
      attitude_word_t e;
      if (pending.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (data[32*i +: 32] !== e.f[i]) begin
          $error("%s expected %0d actual %0d", names[i], e.f[i],
                 $signed(data[32*i +: 32]));
          errors++;
        end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [31:0]        cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [95:0]        s_axis_tdata = '0;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [9*32-1:0]    m_axis_tdata;
  longint             cycles = 0;
  attitude_scoreboard sb;

  quaternion_gyro_attitude_integrator dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit guards against a hang.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sink: random stalls, including long stretches with tready held high.
  initial begin
    int gap;
    bit burst;
    sb = new();
    @(posedge rst_ni);
    forever begin
      burst = ($urandom_range(0, 9) < 3);
      gap = burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_output(m_axis_tdata);
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_HTS) sb.hts = value; else sb.nen = value[0];
    @(posedge clk_i);
  endtask

  task automatic send_word(bit op, logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                           bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1; s_axis_tuser <= op; s_axis_tdata <= {gz, gy, gx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, gx, gy, gz);
  endtask

  // Wait until every expected word is out, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_rate(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  // Stimulus: directed extremes, then random phases over several settings.
  initial begin
    logic [31:0] hts_set [5] = '{32'd0, 32'hFFFF_FFFF, 32'd2147484, 32'd42949673,
                                 32'h0001_0000};
    int mode;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: clear, zero and extreme rates, saturation.
    send_word(OpClr, '1, '1, '1, 1'b0);
    send_word(OpInt, 32'h0, 32'h0, 32'h0, 1'b0);
    send_word(OpInt, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000, 1'b0);
    send_word(OpInt, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    drain();
    write_reg(REG_NEN, 32'd0);
    write_reg(REG_HTS, 32'hFFFF_FFFF);
    send_word(OpClr, 32'h0, 32'h0, 32'h0, 1'b0);
    for (int i = 0; i < 6; i++)
      send_word(OpInt, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    for (int i = 0; i < 4; i++)
      send_word(OpInt, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    drain();
    // A zero step size leaves the saturated attitude unchanged.
    write_reg(REG_HTS, 32'h0);
    send_word(OpInt, 32'h1234_5678, 32'hDEAD_BEEF, 32'h5555_AAAA, 1'b0);
    drain();
    write_reg(REG_HTS, 32'h8000_0000);
    write_reg(REG_NEN, 32'd1);
    send_word(OpClr, 32'h0, 32'h0, 32'h0, 1'b0);
    send_word(OpInt, 32'h0200_0000, 32'h0, 32'h0, 1'b0);
    send_word(OpInt, 32'h0200_0000, 32'h0, 32'h0, 1'b0);
    drain();

    // Random phases: each with its own step size and normalization setting.
    for (int ph = 0; ph < 14; ph++) begin
      write_reg(REG_HTS, ph < 5 ? hts_set[ph] : $urandom());
      write_reg(REG_NEN, 32'(ph % 3 != 2));
      for (int i = 0; i < 100; i++) begin
        mode = $urandom_range(0, 3);
        send_word($urandom_range(0, 30) == 0 ? OpClr : OpInt, rand_rate(mode),
                  rand_rate(mode), rand_rate(mode), $urandom_range(0, 3) == 0);
      end
      drain();
    end
    repeat (250) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[quaternion_gyro_attitude_integrator.f]
rtl/qgai_pkg.sv
rtl/qgai_ctrl.sv
rtl/qgai_dp.sv
rtl/quaternion_gyro_attitude_integrator.sv
sim/tb_quaternion_gyro_attitude_integrator.sv
